// ===== rtl/msp_pkg.sv =====
// ---------------------------------------------------------------------------
// msp_pkg
// Shared types and constants for the min-tracking stack core.
// ---------------------------------------------------------------------------
package msp_pkg;

  localparam int DEFAULT_STACK_DEPTH = 256;
  localparam int VALUE_W             = 32;
  localparam int ENTRY_W             = 2 * VALUE_W;
  localparam int COUNT_W             = 9;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE     = 1'b0,
    ST_POP_WAIT = 1'b1
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== rtl/msp_stack_mem.sv =====
// ---------------------------------------------------------------------------
// msp_stack_mem
// Entry store: one write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module msp_stack_mem
  import msp_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
  parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
  input  logic               clk,
  input  mem_ctl_t           ctl,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/msp_ctrl.sv =====
// ---------------------------------------------------------------------------
// msp_ctrl
// Request sequencer: holds the fill level and a cached copy of the top entry,
// writes pushes to the store and refills the cache from it after a pop.
// ---------------------------------------------------------------------------
module msp_ctrl
  import msp_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
  parameter int ADDR_W      = $clog2(STACK_DEPTH),
  parameter int LVL_W       = $clog2(STACK_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      req_type,
  input  logic signed [VALUE_W-1:0] push_value,
  output logic                      done,
  output logic signed [VALUE_W-1:0] top_value,
  output logic signed [VALUE_W-1:0] min_value,
  output logic [COUNT_W-1:0]        entry_count,
  output logic                      is_empty,
  output logic [1:0]                status,
  output mem_ctl_t                  mem_ctl,
  output logic [ADDR_W-1:0]         wr_addr,
  output logic [ENTRY_W-1:0]        wr_data,
  output logic [ADDR_W-1:0]         rd_addr,
  input  logic [ENTRY_W-1:0]        rd_data
);

  localparam logic [LVL_W-1:0] FULL_LEVEL = LVL_W'(STACK_DEPTH);

  state_t                    state, state_next;
  logic [LVL_W-1:0]          level, level_next;
  logic signed [VALUE_W-1:0] top_val, top_val_next;
  logic signed [VALUE_W-1:0] top_min, top_min_next;
  logic                      done_next;
  logic signed [VALUE_W-1:0] res_top_next, res_min_next;
  logic                      res_empty_next;
  status_t                   res_status_next;
  logic signed [VALUE_W-1:0] run_min;
  logic [LVL_W-1:0]          level_m2;
  logic [LVL_W+COUNT_W-1:0]  level_ext;

  assign busy = (state != ST_IDLE);

  // Pushes keep the older minimum unless the new value is strictly smaller.
  assign run_min  = (level != '0 && !(push_value < top_min)) ? top_min : push_value;
  assign level_m2 = level - LVL_W'(2);

  always_comb begin
    state_next      = state;
    level_next      = level;
    top_val_next    = top_val;
    top_min_next    = top_min;
    done_next       = 1'b0;
    res_top_next    = top_val;
    res_min_next    = top_min;
    res_empty_next  = (level == '0);
    res_status_next = STATUS_OK;
    mem_ctl         = '0;
    wr_addr         = level[ADDR_W-1:0];
    wr_data         = {run_min, push_value};
    rd_addr         = level_m2[ADDR_W-1:0];

    case (state)
      ST_IDLE: begin
        if (start) begin
          if (req_type == REQ_PUSH) begin
            done_next = 1'b1;
            if (level == FULL_LEVEL) begin
              res_status_next = STATUS_OVERFLOW;
            end else begin
              mem_ctl.wr_en  = 1'b1;
              level_next     = level + LVL_W'(1);
              top_val_next   = push_value;
              top_min_next   = run_min;
              res_top_next   = push_value;
              res_min_next   = run_min;
              res_empty_next = 1'b0;
            end
          end else begin
            if (level == '0) begin
              done_next       = 1'b1;
              res_status_next = STATUS_UNDERFLOW;
            end else if (level == LVL_W'(1)) begin
              done_next      = 1'b1;
              level_next     = '0;
              res_empty_next = 1'b1;
            end else begin
              // The entry below the top has to come back from the store.
              mem_ctl.rd_en = 1'b1;
              level_next    = level - LVL_W'(1);
              state_next    = ST_POP_WAIT;
            end
          end
        end
      end
      ST_POP_WAIT: begin
        done_next      = 1'b1;
        top_val_next   = rd_data[VALUE_W-1:0];
        top_min_next   = rd_data[ENTRY_W-1:VALUE_W];
        res_top_next   = rd_data[VALUE_W-1:0];
        res_min_next   = rd_data[ENTRY_W-1:VALUE_W];
        res_empty_next = 1'b0;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      level <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      level <= level_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    top_val   <= top_val_next;
    top_min   <= top_min_next;
    top_value <= res_empty_next ? '0 : res_top_next;
    min_value <= res_empty_next ? '0 : res_min_next;
    is_empty  <= res_empty_next;
    status    <= res_status_next;
  end

  assign level_ext   = {{COUNT_W{1'b0}}, level};
  assign entry_count = level_ext[COUNT_W-1:0];

endmodule

// ===== rtl/min_stack_paired_entries_core.sv =====
// ---------------------------------------------------------------------------
// min_stack_paired_entries_core
// Stack of signed values that reports the running minimum with every result.
// ---------------------------------------------------------------------------
// Results are registered; a pop that leaves entries first waits in ST_POP_WAIT for the store read.
// Throughput: one item per cycle; a pop that leaves entries holds busy while it waits for the store read.
// Reset empties the stack; store contents stay undefined until pushed.
// The result strobe done lasts one cycle and cannot be stalled.
module min_stack_paired_entries_core
  import msp_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      req_type,
  input  logic signed [VALUE_W-1:0] push_value,
  output logic                      done,
  output logic signed [VALUE_W-1:0] top_value,
  output logic signed [VALUE_W-1:0] min_value,
  output logic [COUNT_W-1:0]        entry_count,
  output logic                      is_empty,
  output logic [1:0]                status
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);

  mem_ctl_t           mem_ctl;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  msp_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_W      (ADDR_W),
    .LVL_W       (LVL_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .push_value  (push_value),
    .done        (done),
    .top_value   (top_value),
    .min_value   (min_value),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .status      (status),
    .mem_ctl     (mem_ctl),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  msp_stack_mem #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
